/* rtl/acec_pkg.sv */
`timescale 1ns / 1ps
package acec_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int SAMPLE_W     = 16;

  localparam int PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LEN_W   = PTR_W + 1;            // holds 1..WINDOW_DEPTH
  localparam int SUM_W   = SAMPLE_W + PTR_W;     // signed window sum
  localparam int DIVC_W  = $clog2(SUM_W);
  localparam int DIF_W   = ((SAMPLE_W > 16) ? SAMPLE_W : 16) + 1;
  localparam int SYN_W   = DIF_W + 3;            // 2|dx| + 3|dy|

  localparam int REQ_W   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_TH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_TH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_X_TH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_Y_TH = 3'd6;

  // event codes
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_LEFT   = 3'd1;
  localparam logic [2:0] EV_RIGHT  = 3'd2;
  localparam logic [2:0] EV_BRAKE  = 3'd3;
  localparam logic [2:0] EV_ACCEL  = 3'd4;
  localparam logic [2:0] EV_SMALL  = 3'd5;
  localparam logic [2:0] EV_MIDDLE = 3'd6;
  localparam logic [2:0] EV_LARGE  = 3'd7;

  // harsh limits, 1/1024 g
  localparam int HARSH_ACCEL_LIM = -307;
  localparam int HARSH_BRAKE_LIM = 358;
  localparam int HARSH_RIGHT_LIM = 358;
  localparam int HARSH_LEFT_LIM  = -358;

  localparam logic [REQ_W-1:0] WIN_LEN_RST = 6'd25;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [REQ_W-1:0]   req_len;
    logic [15:0]        large_th;
    logic [15:0]        middle_th;
    logic [14:0]        small_x_th;
    logic [14:0]        small_y_th;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic sum_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sum_last;
    logic div_last;
    logic out_free;
  } dp_sts_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [REQ_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (int'(v) > WINDOW_DEPTH) begin
      r = LEN_W'(WINDOW_DEPTH);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/accel_crash_event_classifier_unit.sv */
`timescale 1ns / 1ps
// Crash / harsh-driving classifier. Each input transfer carries one calibrated
// X/Y sample (signed Q5.10 g), the event code now active and the calibration
// flag; each produces exactly one 3-bit event code on the output channel.
// The sample goes into 32-entry X and Y window stores (zeroed at reset, no
// clearing pass), the first active-length entries are averaged with
// truncation toward zero, and the sample and averages are classified by
// priority into large/middle/small accident or harsh accel/brake/right/left.
// After the input transfer (len = active window length, 1..32) the item goes
// through summing of len entries over the single read port of the
// window stores, a divider setup step, a bit-serial restoring divider over
// the 21-bit window sums, and a classify step that loads the output register.
// The block then goes idle and only then takes the next input transfer, so
// it does not take a new sample before it is through with the last one. A
// loaded result may wait in the output register for its transfer while the
// next item runs; that item holds in its classify step until the output
// register frees up.
// Configuration writes are always ready and take effect at once; write
// them only while no item is in flight.
module accel_crash_event_classifier_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input samples
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [acec_pkg::SAMPLE_W-1:0] in_accel_x,
  input  logic signed [acec_pkg::SAMPLE_W-1:0] in_accel_y,
  input  logic [2:0]                           in_current_event,
  input  logic                                 in_calibration_done,
  // results
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_event_code,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [acec_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [acec_pkg::CFG_DATA_W-1:0]      cfg_data
);

  acec_pkg::cfg_t      cfg;
  acec_pkg::ctrl_cmd_t cmd;
  acec_pkg::dp_sts_t   sts;

  // register file
  acec_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: idle -> sum -> divider setup -> divide -> classify
  acec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // window stores, accumulators, divider, classifier, output register
  acec_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg                 (cfg),
    .in_accel_x          (in_accel_x),
    .in_accel_y          (in_accel_y),
    .in_current_event    (in_current_event),
    .in_calibration_done (in_calibration_done),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_code      (out_event_code)
  );

endmodule

/* rtl/acec_regs.sv */
`timescale 1ns / 1ps
module acec_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [acec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [acec_pkg::CFG_DATA_W-1:0]    cfg_data,
  output acec_pkg::cfg_t                     cfg
);

  acec_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_x   <= '0;
      cfg_r.offset_y   <= '0;
      cfg_r.req_len    <= acec_pkg::WIN_LEN_RST;
      cfg_r.large_th   <= 16'd10240;
      cfg_r.middle_th  <= 16'd6144;
      cfg_r.small_x_th <= 15'd717;
      cfg_r.small_y_th <= 15'd614;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        acec_pkg::REG_OFFSET_X:   cfg_r.offset_x   <= $signed(cfg_data);
        acec_pkg::REG_OFFSET_Y:   cfg_r.offset_y   <= $signed(cfg_data);
        acec_pkg::REG_WIN_LEN:    cfg_r.req_len    <= cfg_data[acec_pkg::REQ_W-1:0];
        acec_pkg::REG_LARGE_TH:   cfg_r.large_th   <= cfg_data;
        acec_pkg::REG_MIDDLE_TH:  cfg_r.middle_th  <= cfg_data;
        acec_pkg::REG_SMALL_X_TH: cfg_r.small_x_th <= cfg_data[14:0];
        acec_pkg::REG_SMALL_Y_TH: cfg_r.small_y_th <= cfg_data[14:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

/* rtl/acec_ctrl.sv */
`timescale 1ns / 1ps
module acec_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  acec_pkg::dp_sts_t     sts,
  output acec_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUM   = 5'b00010,
    S_PREP  = 5'b00100,
    S_DIV   = 5'b01000,
    S_CLASS = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.div_init = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_CLASS;
      end
      S_CLASS: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/acec_dp.sv */
`timescale 1ns / 1ps
module acec_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  acec_pkg::ctrl_cmd_t                  cmd,
  output acec_pkg::dp_sts_t                    sts,
  input  acec_pkg::cfg_t                       cfg,
  input  logic signed [acec_pkg::SAMPLE_W-1:0] in_accel_x,
  input  logic signed [acec_pkg::SAMPLE_W-1:0] in_accel_y,
  input  logic [2:0]                           in_current_event,
  input  logic                                 in_calibration_done,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_event_code
);

  localparam int SW  = acec_pkg::SAMPLE_W;
  localparam int PW  = acec_pkg::PTR_W;
  localparam int LW  = acec_pkg::LEN_W;
  localparam int SMW = acec_pkg::SUM_W;
  localparam int DW  = acec_pkg::DIF_W;
  localparam int YW  = acec_pkg::SYN_W;

  // window stores, cleared at reset
  logic signed [SW-1:0] win_x_r [acec_pkg::WINDOW_DEPTH];
  logic signed [SW-1:0] win_y_r [acec_pkg::WINDOW_DEPTH];

  logic [PW-1:0]          wp_r, idx_r;
  logic [LW-1:0]          act_len_r, len_r;
  logic signed [SW-1:0]   sx_r, sy_r;
  logic [2:0]             cur_r;
  logic                   cal_r;
  logic signed [SMW-1:0]  sum_x_r, sum_y_r;
  logic [SMW-1:0]         dvd_x_r, dvd_y_r;
  logic [LW-1:0]          rem_x_r, rem_y_r;
  logic                   neg_x_r, neg_y_r;
  logic [acec_pkg::DIVC_W-1:0] cnt_r;
  logic                   out_valid_r;
  logic [2:0]             code_r;

  // pointer advance
  logic [LW-1:0] wp_inc;
  assign wp_inc = LW'(wp_r) + LW'(1);

  // one restoring divide step per axis
  logic [LW:0]   trial_x, trial_y;
  logic          ge_x, ge_y;
  assign trial_x = {rem_x_r, dvd_x_r[SMW-1]};
  assign trial_y = {rem_y_r, dvd_y_r[SMW-1]};
  assign ge_x    = trial_x >= {1'b0, len_r};
  assign ge_y    = trial_y >= {1'b0, len_r};

  assign sts.sum_last = ({1'b0, idx_r} == LW'(len_r - LW'(1)));
  assign sts.div_last = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || !out_stall;

  // classification
  logic signed [SMW-1:0] avg_x, avg_y;
  logic signed [DW-1:0]  dx, dy, ax, ay;
  logic [DW-1:0]         mdx, mdy, max_, may;
  logic [YW-1:0]         syn2;
  logic [2:0]            code;

  assign avg_x = neg_x_r ? -$signed(dvd_x_r) : $signed(dvd_x_r);
  assign avg_y = neg_y_r ? -$signed(dvd_y_r) : $signed(dvd_y_r);
  assign dx    = DW'(sx_r) - DW'(cfg.offset_x);
  assign dy    = DW'(sy_r) - DW'(cfg.offset_y);
  assign ax    = DW'(avg_x) - DW'(cfg.offset_x);
  assign ay    = DW'(avg_y) - DW'(cfg.offset_y);
  assign mdx   = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign mdy   = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign max_  = ax[DW-1] ? DW'(-ax) : DW'(ax);
  assign may   = ay[DW-1] ? DW'(-ay) : DW'(ay);
  assign syn2  = (YW'(mdx) << 1) + (YW'(mdy) << 1) + YW'(mdy);

  always_comb begin
    code = acec_pkg::EV_NONE;
    if (cal_r) begin
      priority if (syn2 > YW'({cfg.large_th, 1'b0}) && cur_r < acec_pkg::EV_LARGE) begin
        code = acec_pkg::EV_LARGE;
      end else if (syn2 > YW'({cfg.middle_th, 1'b0}) && cur_r < acec_pkg::EV_MIDDLE) begin
        code = acec_pkg::EV_MIDDLE;
      end else if ((max_ > DW'(cfg.small_x_th) || may > DW'(cfg.small_y_th))
                   && cur_r < acec_pkg::EV_SMALL) begin
        code = acec_pkg::EV_SMALL;
      end else if (ax < DW'(acec_pkg::HARSH_ACCEL_LIM) && cur_r == acec_pkg::EV_NONE) begin
        code = acec_pkg::EV_ACCEL;
      end else if (ax > DW'(acec_pkg::HARSH_BRAKE_LIM) && cur_r == acec_pkg::EV_NONE) begin
        code = acec_pkg::EV_BRAKE;
      end else if (ay > DW'(acec_pkg::HARSH_RIGHT_LIM) && cur_r == acec_pkg::EV_NONE) begin
        code = acec_pkg::EV_RIGHT;
      end else if (ay < DW'(acec_pkg::HARSH_LEFT_LIM) && cur_r == acec_pkg::EV_NONE) begin
        code = acec_pkg::EV_LEFT;
      end else begin
        code = acec_pkg::EV_NONE;
      end
    end
  end

  // window stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < acec_pkg::WINDOW_DEPTH; i++) begin
        win_x_r[i] <= '0;
        win_y_r[i] <= '0;
      end
    end else if (cmd.start) begin
      win_x_r[wp_r] <= in_accel_x;
      win_y_r[wp_r] <= in_accel_y;
    end
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      act_len_r   <= acec_pkg::clamp_len(acec_pkg::WIN_LEN_RST);
      len_r       <= acec_pkg::clamp_len(acec_pkg::WIN_LEN_RST);
      idx_r       <= '0;
      cnt_r       <= '0;
      rem_x_r     <= '0;
      rem_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        wp_r  <= (wp_inc >= act_len_r) ? '0 : PW'(wp_inc);
        len_r <= act_len_r;
        idx_r <= '0;
        if (in_current_event == acec_pkg::EV_NONE) begin
          act_len_r <= acec_pkg::clamp_len(cfg.req_len);
        end
      end
      if (cmd.sum_step) idx_r <= idx_r + PW'(1);
      if (cmd.div_init) begin
        cnt_r   <= acec_pkg::DIVC_W'(SMW - 1);
        rem_x_r <= '0;
        rem_y_r <= '0;
      end
      if (cmd.div_step) begin
        cnt_r   <= cnt_r - acec_pkg::DIVC_W'(1);
        rem_x_r <= ge_x ? LW'(trial_x - {1'b0, len_r}) : LW'(trial_x);
        rem_y_r <= ge_y ? LW'(trial_y - {1'b0, len_r}) : LW'(trial_y);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sx_r    <= in_accel_x;
      sy_r    <= in_accel_y;
      cur_r   <= in_current_event;
      cal_r   <= in_calibration_done;
      sum_x_r <= '0;
      sum_y_r <= '0;
    end
    if (cmd.sum_step) begin
      sum_x_r <= sum_x_r + SMW'(win_x_r[idx_r]);
      sum_y_r <= sum_y_r + SMW'(win_y_r[idx_r]);
    end
    if (cmd.div_init) begin
      neg_x_r <= sum_x_r[SMW-1];
      neg_y_r <= sum_y_r[SMW-1];
      dvd_x_r <= sum_x_r[SMW-1] ? SMW'(-sum_x_r) : SMW'(sum_x_r);
      dvd_y_r <= sum_y_r[SMW-1] ? SMW'(-sum_y_r) : SMW'(sum_y_r);
    end
    if (cmd.div_step) begin
      dvd_x_r <= {dvd_x_r[SMW-2:0], ge_x};
      dvd_y_r <= {dvd_y_r[SMW-2:0], ge_y};
    end
    if (cmd.load_out) code_r <= code;
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = code_r;

  a_idx_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum_step |-> ({1'b0, idx_r} < len_r))
    else $error("window read beyond active length");

  a_wp_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (LW'(wp_r) < len_r))
    else $error("write pointer not wrapped to window length");

  // remainders restart at div_init, so they are bounded while dividing
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> ((rem_x_r < len_r) && (rem_y_r < len_r)))
    else $error("divider remainder out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result overwritten before transfer");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.sum_step, cmd.div_init, cmd.div_step, cmd.load_out}))
    else $error("overlapping datapath commands");

endmodule
